@@ rtl/core/jfep_pkg.sv @@
package jfep_pkg;

    localparam int CHUNK_W  = 12;
    localparam int HEADER_W = 32;
    localparam int LEN_W    = 32;
    localparam int IDX_W    = 4;

    localparam logic [7:0] MARK_FF  = 8'hFF;
    localparam logic [7:0] MARK_SOI = 8'hD8;
    localparam logic [7:0] MARK_EOI = 8'hD9;

    localparam logic [CHUNK_W-1:0]  CHUNK_SIZE_RST  = 12'd1460;
    localparam logic [HEADER_W-1:0] HEADER_WORD_RST = 32'h5445_5354;

    // fill right after a start marker: header plus FF D8; length: FF D8 only
    localparam logic [CHUNK_W-1:0] SOI_FILL = 12'd6;
    localparam logic [LEN_W-1:0]   SOI_LEN  = 32'd2;

    // position of the final result in each start and end burst
    localparam logic [IDX_W-1:0] SOI_LAST = 4'd5;
    localparam logic [IDX_W-1:0] EOI_LAST = 4'd8;

    typedef enum logic {
        CFG_CHUNK_SIZE  = 1'b0,
        CFG_HEADER_WORD = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_SOI,
        KIND_EOI
    } burst_kind_t;

    // what one accepted byte asks the emitter to send
    typedef struct packed {
        logic              valid;
        burst_kind_t       kind;
        logic [7:0]        data;
        logic              pe;
        logic [LEN_W-1:0]  length;
    } jfep_desc_t;

endpackage

@@ rtl/core/jfep_in_if.sv @@
interface jfep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] fifo_byte;

    modport source (output valid, output fifo_byte, input ready);
    modport sink   (input valid, input fifo_byte, output ready);
endinterface

@@ rtl/core/jfep_out_if.sv @@
interface jfep_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_end;
    logic       frame_end;
    logic       run_last;

    modport source (output valid, output out_byte, output packet_end,
                    output frame_end, output run_last, input ready);
    modport sink   (input valid, input out_byte, input packet_end,
                    input frame_end, input run_last, output ready);
endinterface

@@ rtl/core/jfep_parser.sv @@
module jfep_parser
    import jfep_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         fifo_byte,
    input  logic [CHUNK_W-1:0] chunk_size,
    output jfep_desc_t         desc
);

    logic               in_frame_reg, in_frame_next;
    logic [7:0]         prev_byte_reg;
    logic [CHUNK_W-1:0] fill_count_reg, fill_count_next;
    logic [LEN_W-1:0]   frame_length_reg, frame_length_next;

    logic [CHUNK_W-1:0] fill_inc;
    logic [LEN_W-1:0]   len_inc;
    logic               prev_ff;

    assign prev_ff  = (prev_byte_reg == MARK_FF);
    assign fill_inc = fill_count_reg + CHUNK_W'(1);
    assign len_inc  = frame_length_reg + LEN_W'(1);

    always_comb
    begin
        in_frame_next     = in_frame_reg;
        fill_count_next   = fill_count_reg;
        frame_length_next = frame_length_reg;
        desc.valid        = 1'b0;
        desc.kind         = KIND_DATA;
        desc.data         = fifo_byte;
        desc.pe           = 1'b0;
        desc.length       = len_inc;
        if (!in_frame_reg)
        begin
            if (prev_ff && fifo_byte == MARK_SOI)
            begin
                desc.valid        = 1'b1;
                desc.kind         = KIND_SOI;
                in_frame_next     = 1'b1;
                fill_count_next   = SOI_FILL;
                frame_length_next = SOI_LEN;
            end
        end
        else
        begin
            desc.valid        = 1'b1;
            frame_length_next = len_inc;
            fill_count_next   = fill_inc;
            if (prev_ff && fifo_byte == MARK_EOI)
            begin
                desc.kind       = KIND_EOI;
                fill_count_next = '0;
                in_frame_next   = 1'b0;
            end
            else if (fill_inc >= chunk_size)
            begin
                desc.pe         = 1'b1;
                fill_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg     <= 1'b0;
            prev_byte_reg    <= '0;
            fill_count_reg   <= '0;
            frame_length_reg <= '0;
        end
        else if (accept)
        begin
            in_frame_reg     <= in_frame_next;
            prev_byte_reg    <= fifo_byte;
            fill_count_reg   <= fill_count_next;
            frame_length_reg <= frame_length_next;
        end
    end

endmodule

@@ rtl/core/jfep_emitter.sv @@
module jfep_emitter
    import jfep_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  jfep_desc_t          desc,
    input  logic [HEADER_W-1:0] header_word,
    output logic                free,
    jfep_out_if.source          out_ch
);

    logic              busy_reg;
    burst_kind_t       kind_reg;
    logic [7:0]        data_reg;
    logic              pe_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic       last;
    logic [7:0] byte_sel;
    logic       pe_sel;
    logic       fe_sel;
    logic       out_take;

    always_comb
    begin
        byte_sel = data_reg;
        pe_sel   = 1'b0;
        fe_sel   = 1'b0;
        last     = 1'b0;
        case (kind_reg)
            KIND_DATA:
            begin
                pe_sel = pe_reg;
                last   = 1'b1;
            end
            KIND_SOI:
            begin
                last = (idx_reg == SOI_LAST);
                case (idx_reg)
                    4'd0:    byte_sel = header_word[31:24];
                    4'd1:    byte_sel = header_word[23:16];
                    4'd2:    byte_sel = header_word[15:8];
                    4'd3:    byte_sel = header_word[7:0];
                    4'd4:    byte_sel = MARK_FF;
                    default: byte_sel = MARK_SOI;
                endcase
            end
            KIND_EOI:
            begin
                last   = (idx_reg == EOI_LAST);
                pe_sel = last;
                fe_sel = last;
                case (idx_reg)
                    4'd0:    byte_sel = data_reg;
                    4'd5:    byte_sel = len_reg[31:24];
                    4'd6:    byte_sel = len_reg[23:16];
                    4'd7:    byte_sel = len_reg[15:8];
                    4'd8:    byte_sel = len_reg[7:0];
                    default: byte_sel = MARK_FF;
                endcase
            end
            default:
            begin
                last = 1'b1;
            end
        endcase
    end

    assign out_ch.valid      = busy_reg;
    assign out_ch.out_byte   = byte_sel;
    assign out_ch.packet_end = pe_sel;
    assign out_ch.frame_end  = fe_sel;
    assign out_ch.run_last   = last;

    assign out_take = busy_reg && out_ch.ready;
    // a new burst can enter in the cycle the last item of the current one leaves
    assign free     = !busy_reg || (out_take && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            kind_reg <= KIND_DATA;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            kind_reg <= desc.kind;
        end
        else if (out_take)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= desc.data;
            pe_reg   <= desc.pe;
            len_reg  <= desc.length;
        end
    end

endmodule

@@ rtl/core/jpeg_frame_extract_packetizer_top.sv @@
// JPEG frame extractor and packetizer.
// The first result of an item is offered in the cycle after the item is accepted.
// One data byte is taken per cycle while the receiver is ready; a start or end
// marker holds input until its whole burst is out, as there is one result register.
// Reset (rst_n, async low): hunting, counters cleared, chunk_size 1460, header "TEST".
module jpeg_frame_extract_packetizer_top
    import jfep_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [HEADER_W-1:0] cfg_data,
    jfep_in_if.sink             in_ch,
    jfep_out_if.source          out_ch
);

    logic [CHUNK_W-1:0]  chunk_size_reg;
    logic [HEADER_W-1:0] header_word_reg;
    logic                free;
    logic                accept;
    jfep_desc_t          desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_size_reg  <= CHUNK_SIZE_RST;
            header_word_reg <= HEADER_WORD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_CHUNK_SIZE:  chunk_size_reg  <= cfg_data[CHUNK_W-1:0];
                CFG_HEADER_WORD: header_word_reg <= cfg_data;
                default:         header_word_reg <= header_word_reg;
            endcase
        end
    end

    assign in_ch.ready = free;
    assign accept      = in_ch.valid && free;

    jfep_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .fifo_byte  (in_ch.fifo_byte),
        .chunk_size (chunk_size_reg),
        .desc       (desc)
    );

    jfep_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept && desc.valid),
        .desc        (desc),
        .header_word (header_word_reg),
        .free        (free),
        .out_ch      (out_ch)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
    import jfep_pkg::*;
;

    localparam int LONG_HOLD = 60;

    typedef struct packed {
        logic [7:0] data;
        logic       pe;
        logic       fe;
        logic       last;
    } pkt_byte_t;

    // Tracks the extractor state and holds the bytes it should send next.
    class frame_scoreboard;
        logic [CHUNK_W-1:0]  chunk_size;
        logic [HEADER_W-1:0] header_word;
        bit                  in_frame;
        logic [7:0]          prev_byte;
        logic [CHUNK_W-1:0]  fill_count;
        logic [LEN_W-1:0]    frame_length;
        pkt_byte_t           expected_bytes[$];
        int                  failures;
        int                  bytes_in;
        int                  bytes_out;
        int                  frames_opened;
        int                  frames_closed;
        int                  packet_breaks;

        function new();
            chunk_size    = CHUNK_SIZE_RST;
            header_word   = HEADER_WORD_RST;
            in_frame      = 0;
            prev_byte     = 8'h00;
            fill_count    = '0;
            frame_length  = '0;
            failures      = 0;
            bytes_in      = 0;
            bytes_out     = 0;
            frames_opened = 0;
            frames_closed = 0;
            packet_breaks = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [HEADER_W-1:0] value);
            case (idx)
                CFG_CHUNK_SIZE:  chunk_size = value[CHUNK_W-1:0];
                CFG_HEADER_WORD: header_word = value;
                default:         ;
            endcase
        endfunction

        function void add(logic [7:0] d, logic pe, logic fe, logic last);
            pkt_byte_t e;
            e.data = d;
            e.pe   = pe;
            e.fe   = fe;
            e.last = last;
            expected_bytes.push_back(e);
        endfunction

        function void note_byte(logic [7:0] b);
            logic [7:0] last_b;
            last_b    = prev_byte;
            prev_byte = b;
            bytes_in++;
            if (!in_frame)
            begin
                if (last_b == MARK_FF && b == MARK_SOI)
                begin
                    for (int i = 3; i >= 0; i--)
                        add(header_word[8*i +: 8], 1'b0, 1'b0, 1'b0);
                    add(MARK_FF, 1'b0, 1'b0, 1'b0);
                    add(MARK_SOI, 1'b0, 1'b0, 1'b1);
                    fill_count   = SOI_FILL;
                    frame_length = SOI_LEN;
                    in_frame     = 1;
                    frames_opened++;
                end
            end
            else
            begin
                frame_length = frame_length + 1'b1;
                fill_count   = fill_count + 1'b1;
                if (last_b == MARK_FF && b == MARK_EOI)
                begin
                    add(b, 1'b0, 1'b0, 1'b0);
                    repeat (4) add(MARK_FF, 1'b0, 1'b0, 1'b0);
                    for (int i = 3; i >= 1; i--)
                        add(frame_length[8*i +: 8], 1'b0, 1'b0, 1'b0);
                    add(frame_length[7:0], 1'b1, 1'b1, 1'b1);
                    fill_count = '0;
                    in_frame   = 0;
                    frames_closed++;
                end
                else if (fill_count >= chunk_size)
                begin
                    add(b, 1'b1, 1'b0, 1'b1);
                    fill_count = '0;
                    packet_breaks++;
                end
                else
                begin
                    add(b, 1'b0, 1'b0, 1'b1);
                end
            end
        endfunction

        function void check_result(pkt_byte_t got);
            pkt_byte_t want;
            bytes_out++;
            if (expected_bytes.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected byte %02h pe=%0b fe=%0b last=%0b",
                             $realtime, got.data, got.pe, got.fe, got.last);
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("%0t: byte %0d mismatch: expected %02h pe=%0b fe=%0b last=%0b,",
                             $realtime, bytes_out, want.data, want.pe, want.fe, want.last);
                    $display("    got %02h pe=%0b fe=%0b last=%0b",
                             got.data, got.pe, got.fe, got.last);
                end
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    cfg_index_t          cfg_index;
    logic [HEADER_W-1:0] cfg_data;

    jfep_in_if  in_ch();
    jfep_out_if out_ch();

    frame_scoreboard sb;
    bit              no_gaps;
    int              stall_req;
    int              stall_seen;
    int              hold_left;
    int              settings_used;

    jpeg_frame_extract_packetizer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    always #5 clk = ~clk;

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (stall_req != stall_seen)
        begin
            out_ch.ready <= 1'b0;
            stall_seen   <= stall_req;
            hold_left    <= LONG_HOLD;
        end
        else
        begin
            out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 34);
        end
    end

    always @(posedge clk)
    begin
        pkt_byte_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.data = out_ch.out_byte;
            got.pe   = out_ch.packet_end;
            got.fe   = out_ch.frame_end;
            got.last = out_ch.run_last;
            sb.check_result(got);
        end
    end

    // called at a clock edge; valid may still be high from the previous item
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!no_gaps)
            while ($urandom_range(0, 99) < 34)
                gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.fifo_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_byte(b);
    endtask

    task automatic send_list(input logic [7:0] bytes[$]);
        foreach (bytes[k])
            send_byte(bytes[k]);
    endtask

    // mostly well-formed frames with random content, some noise and open frames
    task automatic send_frames(input int n);
        logic [7:0] q[$];
        int         body;
        while (q.size() < n)
        begin
            repeat ($urandom_range(0, 3))
                q.push_back(8'($urandom_range(0, 255)));
            q.push_back(MARK_FF);
            q.push_back(MARK_SOI);
            body = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 14);
            repeat (body)
                q.push_back(($urandom_range(0, 9) == 0) ? MARK_FF
                                                        : 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) != 0)
            begin
                q.push_back(MARK_FF);
                q.push_back(MARK_EOI);
            end
        end
        send_list(q);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        // a dropped byte gives no result but may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [HEADER_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CHUNK_W-1:0] chunk, input logic [31:0] hdr);
        cfg_write(CFG_CHUNK_SIZE, {{(HEADER_W-CHUNK_W){1'b0}}, chunk});
        cfg_write(CFG_HEADER_WORD, hdr);
        settings_used++;
    endtask

    initial
    begin
        logic [7:0] open_frame[$];
        logic [7:0] seq[$];
        sb              = new();
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_CHUNK_SIZE;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.fifo_byte = 8'h00;
        out_ch.ready    = 1'b0;
        no_gaps         = 0;
        stall_req       = 0;
        stall_seen      = 0;
        hold_left       = 0;
        settings_used   = 1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: lone markers while hunting, FF FF D8, markers inside
        // a frame, D8 right after an end, and an empty frame
        seq = {8'h00, MARK_FF, MARK_EOI, MARK_SOI, MARK_FF, MARK_FF, MARK_SOI,
               8'h00, MARK_FF, MARK_SOI, 8'h7F, MARK_FF, MARK_FF, MARK_EOI,
               MARK_SOI, MARK_FF, MARK_SOI, MARK_FF, MARK_EOI, 8'h55, 8'hAA};
        send_list(seq);
        drain();

        // chunk of eight, no idling anywhere
        set_config(12'd8, 32'h0000_0000);
        no_gaps = 1;
        send_frames(35);
        drain();
        no_gaps = 0;

        // chunk of zero closes every data byte; long receiver hold-off
        set_config(12'd0, 32'hFFFF_FFFF);
        stall_req++;
        send_frames(35);
        drain();

        // chunk of 2048; sender pauses for all results mid-stream
        set_config(12'd2048, $urandom());
        send_frames(17);
        drain();
        send_frames(17);

        // leave a frame open with a large fill count
        open_frame = {MARK_FF, MARK_EOI, MARK_FF, MARK_SOI};
        repeat (20)
            open_frame.push_back(8'($urandom_range(0, 254)));
        send_list(open_frame);
        drain();

        // chunk lowered mid-packet closes it on the next data byte
        set_config(12'd12, $urandom());
        send_frames(35);
        drain();

        set_config(12'd4095, $urandom());
        send_frames(28);
        drain();

        set_config(12'd1, $urandom());
        send_frames(35);
        drain();

        set_config(12'($urandom_range(8, 64)), $urandom());
        send_frames(28);
        drain();
        repeat (10) @(posedge clk);

        if (sb.pending() != 0)
        begin
            sb.failures++;
            $display("%0d expected bytes never arrived", sb.pending());
        end
        $display("Sent %0d bytes under %0d register settings; %0d bytes out checked.",
                 sb.bytes_in, settings_used, sb.bytes_out);
        $display("Frames opened %0d, closed %0d, chunk boundaries %0d, failures %0d.",
                 sb.frames_opened, sb.frames_closed, sb.packet_breaks, sb.failures);
        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d bytes still expected", sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
